FILE: src/twgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twgd_pkg: shared types and constants of the touch wheel gesture decoder
// item kinds, result codes, register indexes, reset values, arctangent table
// ----------------------------------------------------------------------------
package twgd_pkg;

  // default angle resolution in bits of one turn
  localparam int unsigned ANGLE_BITS_DEFAULT = 16;

  // cordic iterations and table of atan(2^-i) in 32-bit turn units
  localparam int unsigned CORDIC_STEPS = 24;
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // minimum squared move distance for a rotation step
  localparam logic [18:0] MIN_MOVE_SQ = 19'd64;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_RADIUS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER_RADIUS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_RADIUS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIFT_LIMIT   = 3'd5;

  // register reset values
  localparam logic [7:0] CENTER_X_RESET      = 8'd128;
  localparam logic [7:0] CENTER_Y_RESET      = 8'd96;
  localparam logic [6:0] INNER_RADIUS_RESET  = 7'd24;
  localparam logic [6:0] OUTER_RADIUS_RESET  = 7'd76;
  localparam logic [6:0] CENTER_RADIUS_RESET = 7'd40;
  localparam logic [6:0] DRIFT_LIMIT_RESET   = 7'd40;

  // rotation codes
  localparam logic [1:0] ROT_NONE  = 2'd0;
  localparam logic [1:0] ROT_RIGHT = 2'd1;
  localparam logic [1:0] ROT_LEFT  = 2'd2;

  // button codes
  localparam logic [2:0] BTN_NONE    = 3'd0;
  localparam logic [2:0] BTN_CENTER  = 3'd1;
  localparam logic [2:0] BTN_MENU    = 3'd2;
  localparam logic [2:0] BTN_PLAY    = 3'd3;
  localparam logic [2:0] BTN_FORWARD = 3'd4;
  localparam logic [2:0] BTN_REWIND  = 3'd5;

  // what a sample means given the pen history
  typedef enum logic [1:0] {
    KIND_HOVER,   // pen up while already up
    KIND_PRESS,   // first pen-down sample
    KIND_DRAG,    // pen-down sample while already down
    KIND_RELEASE  // pen lifted after being down
  } kind_e;

  // one classified sample, coordinates relative to the wheel center
  typedef struct packed {
    kind_e              kind;
    logic signed [8:0]  px;
    logic signed [8:0]  py;
  } item_t;

  // ring and tap settings used by the back end
  typedef struct packed {
    logic [6:0] inner_radius;
    logic [6:0] outer_radius;
    logic [6:0] center_button_radius;
    logic [6:0] tap_drift_limit;
  } cfg_t;

endpackage

FILE: src/twgd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twgd_front: sample intake
// tracks the pen, tags each sample by kind and moves it to center coordinates
// ----------------------------------------------------------------------------
module twgd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              pen_down_i,
  input  logic [7:0]        touch_x_i,
  input  logic [7:0]        touch_y_i,
  input  logic [7:0]        center_x_i,
  input  logic [7:0]        center_y_i,
  input  logic              full_i,
  output logic              push_o,
  output twgd_pkg::item_t   item_o
);

  logic pen_was_down_q;

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

  always_comb begin
    item_o.px = $signed({1'b0, touch_x_i}) - $signed({1'b0, center_x_i});
    item_o.py = $signed({1'b0, touch_y_i}) - $signed({1'b0, center_y_i});
    if (pen_down_i) begin
      item_o.kind = pen_was_down_q ? twgd_pkg::KIND_DRAG : twgd_pkg::KIND_PRESS;
    end else begin
      item_o.kind = pen_was_down_q ? twgd_pkg::KIND_RELEASE : twgd_pkg::KIND_HOVER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_was_down_q <= 1'b0;
    end else if (push_o) begin
      pen_was_down_q <= pen_down_i;
    end
  end

endmodule

FILE: src/twgd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twgd_queue: short fifo between front and back
// decouples sample intake from the per-sample evaluation
// ----------------------------------------------------------------------------
module twgd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  twgd_pkg::item_t   item_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output twgd_pkg::item_t   item_o
);

  localparam int unsigned PTR_W = (twgd_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(twgd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(twgd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(twgd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(twgd_pkg::QUEUE_DEPTH);

  twgd_pkg::item_t    entries_q [twgd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/twgd_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twgd_cordic: iterative vectoring cordic
// one micro-rotation per cycle, angle of (x, y) as a fraction of a turn
// ----------------------------------------------------------------------------
module twgd_cordic #(
  parameter int unsigned ANGLE_BITS = twgd_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [8:0]      x_i,
  input  logic signed [8:0]      y_i,
  output logic                   done_o,
  output logic [ANGLE_BITS-1:0]  angle_o
);

  localparam int unsigned STEP_W = $clog2(twgd_pkg::CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(twgd_pkg::CORDIC_STEPS - 1);
  localparam logic [31:0] ROUND_BIT = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  logic                busy_q;
  logic                done_q;
  logic                zero_q;
  logic [STEP_W-1:0]   step_q;
  logic signed [27:0]  cx_q;
  logic signed [27:0]  cy_q;
  logic [31:0]         acc_q;

  logic signed [27:0]  x_ext;
  logic signed [27:0]  y_ext;
  logic signed [27:0]  sx;
  logic signed [27:0]  sy;
  logic                cy_pos;
  logic [31:0]         acc_rnd;

  assign x_ext   = {{3{x_i[8]}}, x_i, 16'b0};
  assign y_ext   = {{3{y_i[8]}}, y_i, 16'b0};
  assign sx      = cx_q >>> step_q;
  assign sy      = cy_q >>> step_q;
  assign cy_pos  = !cy_q[27] && (cy_q != '0);
  assign acc_rnd = acc_q + ROUND_BIT;
  assign angle_o = zero_q ? '0 : acc_rnd[31 -: ANGLE_BITS];
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      // left half plane: pre-rotate by half a turn
      if (x_i[8]) begin
        cx_q  <= 28'(-x_ext);
        cy_q  <= 28'(-y_ext);
        acc_q <= HALF_TURN;
      end else begin
        cx_q  <= x_ext;
        cy_q  <= y_ext;
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (cy_pos) begin
        cx_q  <= cx_q + sy;
        cy_q  <= cy_q - sx;
        acc_q <= acc_q + twgd_pkg::ATAN_TURN[step_q];
      end else begin
        cx_q  <= cx_q - sy;
        cy_q  <= cy_q + sx;
        acc_q <= acc_q - twgd_pkg::ATAN_TURN[step_q];
      end
    end
  end

endmodule

FILE: src/twgd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twgd_back: gesture evaluation
// ring test, move test, angle step and tap classification, one sample at a time
// ----------------------------------------------------------------------------
module twgd_back #(
  parameter int unsigned ANGLE_BITS = twgd_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  twgd_pkg::item_t   item_i,
  input  twgd_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [1:0]        rotation_o,
  output logic [2:0]        button_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_ANGLE  = 3'd4;
  localparam logic [2:0] ST_STEP   = 3'd5;

  localparam int unsigned UW = ANGLE_BITS + 5;
  localparam logic [UW-1:0] T_1  = {5'd1,  {ANGLE_BITS{1'b0}}};
  localparam logic [UW-1:0] T_10 = {5'd10, {ANGLE_BITS{1'b0}}};
  localparam logic [UW-1:0] T_17 = {5'd17, {ANGLE_BITS{1'b0}}};

  function automatic logic [7:0] mag9(input logic signed [8:0] v);
    logic [8:0] n;
    begin
      n = v[8] ? 9'(-v) : 9'(v);
      return n[7:0];
    end
  endfunction

  function automatic logic [8:0] mag10(input logic signed [9:0] v);
    logic [9:0] n;
    begin
      n = v[9] ? 10'(-v) : 10'(v);
      return n[8:0];
    end
  endfunction

  // control and gesture state
  logic [2:0]         state_q;
  logic               out_valid_q;
  logic [1:0]         rot_q;
  logic [2:0]         btn_q;
  logic               in_ring_q;
  logic               rotated_q;
  logic signed [8:0]  anchor_x_q;
  logic signed [8:0]  anchor_y_q;
  logic signed [8:0]  press_x_q;
  logic signed [8:0]  press_y_q;
  logic signed [8:0]  last_x_q;
  logic signed [8:0]  last_y_q;

  // working registers of the current sample
  twgd_pkg::item_t    cur_q;
  logic signed [8:0]  va_x_q;
  logic signed [8:0]  va_y_q;
  logic signed [9:0]  vm_x_q;
  logic signed [9:0]  vm_y_q;
  logic               tap_ok_q;
  logic [15:0]        sqa_x_q;
  logic [15:0]        sqa_y_q;
  logic [17:0]        sqm_x_q;
  logic [17:0]        sqm_y_q;
  logic [13:0]        ir_sq_q;
  logic [13:0]        or_sq_q;
  logic [13:0]        cb_sq_q;
  logic [ANGLE_BITS-1:0] ang_new_q;
  logic [ANGLE_BITS-1:0] ang_anc_q;

  // prep stage
  logic signed [8:0]  anc_x;
  logic signed [8:0]  anc_y;
  logic signed [9:0]  sum_x;
  logic signed [9:0]  sum_y;
  logic signed [9:0]  mid_x;
  logic signed [9:0]  mid_y;
  logic signed [9:0]  dft_x;
  logic signed [9:0]  dft_y;
  logic               drift_ok;

  // decide stage
  logic [16:0]        dist_sq;
  logic [18:0]        move_sq;
  logic               outside;
  logic               center_hit;
  logic               move_ok;
  logic [7:0]         ax;
  logic [7:0]         ay;
  logic [2:0]         btn_class;

  // step stage
  logic [ANGLE_BITS-1:0] u;
  logic [UW-1:0]      u18;
  logic [1:0]         rot_step;

  // cordic lanes
  logic               cordic_start;
  logic               done_new;
  logic               done_anc;
  logic [ANGLE_BITS-1:0] angle_new;
  logic [ANGLE_BITS-1:0] angle_anc;

  assign item_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign res_valid_o  = out_valid_q;
  assign rotation_o   = rot_q;
  assign button_o     = btn_q;

  // prep: anchor as seen by this sample, release midpoint and drift
  always_comb begin
    anc_x    = (cur_q.kind == twgd_pkg::KIND_PRESS) ? cur_q.px : anchor_x_q;
    anc_y    = (cur_q.kind == twgd_pkg::KIND_PRESS) ? cur_q.py : anchor_y_q;
    sum_x    = 10'(press_x_q) + 10'(last_x_q);
    sum_y    = 10'(press_y_q) + 10'(last_y_q);
    mid_x    = (sum_x + 10'(sum_x[9])) >>> 1;
    mid_y    = (sum_y + 10'(sum_y[9])) >>> 1;
    dft_x    = 10'(press_x_q) - 10'(last_x_q);
    dft_y    = 10'(press_y_q) - 10'(last_y_q);
    drift_ok = (mag10(dft_x) < {2'b0, cfg_i.tap_drift_limit}) &&
               (mag10(dft_y) < {2'b0, cfg_i.tap_drift_limit});
  end

  // decide: ring test, move test and tap class
  always_comb begin
    dist_sq    = {1'b0, sqa_x_q} + {1'b0, sqa_y_q};
    move_sq    = {1'b0, sqm_x_q} + {1'b0, sqm_y_q};
    outside    = (dist_sq > {3'b0, or_sq_q}) || (dist_sq < {3'b0, ir_sq_q});
    center_hit = (dist_sq <= {3'b0, cb_sq_q});
    move_ok    = (move_sq >= twgd_pkg::MIN_MOVE_SQ);
    ax         = mag9(va_x_q);
    ay         = mag9(va_y_q);
    if (center_hit) begin
      btn_class = twgd_pkg::BTN_CENTER;
    end else if (outside) begin
      btn_class = twgd_pkg::BTN_NONE;
    end else if (ay > ax) begin
      btn_class = va_y_q[8] ? twgd_pkg::BTN_MENU : twgd_pkg::BTN_PLAY;
    end else if (va_x_q[8]) begin
      btn_class = twgd_pkg::BTN_REWIND;
    end else if (va_x_q != '0) begin
      btn_class = twgd_pkg::BTN_FORWARD;
    end else begin
      btn_class = twgd_pkg::BTN_NONE;
    end
    cordic_start = (state_q == ST_DECIDE) && (cur_q.kind != twgd_pkg::KIND_RELEASE) &&
                   !outside && in_ring_q && move_ok;
  end

  // step: angle difference in turn units, times 18 against the sector bounds
  always_comb begin
    u   = ang_new_q - ang_anc_q;
    u18 = ({5'b0, u} << 4) + ({5'b0, u} << 1);
    if ((u18 > T_1) && (u18 < T_10)) begin
      rot_step = twgd_pkg::ROT_RIGHT;
    end else if ((u18 >= T_10) && (u18 < T_17)) begin
      rot_step = twgd_pkg::ROT_LEFT;
    end else begin
      rot_step = twgd_pkg::ROT_NONE;
    end
  end

  twgd_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic_new (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (cur_q.px),
    .y_i     (cur_q.py),
    .done_o  (done_new),
    .angle_o (angle_new)
  );

  twgd_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic_anc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (anchor_x_q),
    .y_i     (anchor_y_q),
    .done_o  (done_anc),
    .angle_o (angle_anc)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    ir_sq_q <= cfg_i.inner_radius * cfg_i.inner_radius;
    or_sq_q <= cfg_i.outer_radius * cfg_i.outer_radius;
    cb_sq_q <= cfg_i.center_button_radius * cfg_i.center_button_radius;
    if (item_valid_i && item_ready_o) begin
      cur_q <= item_i;
    end
    if (state_q == ST_PREP) begin
      if (cur_q.kind == twgd_pkg::KIND_RELEASE) begin
        va_x_q <= mid_x[8:0];
        va_y_q <= mid_y[8:0];
      end else begin
        va_x_q <= cur_q.px;
        va_y_q <= cur_q.py;
      end
      vm_x_q   <= 10'(cur_q.px) - 10'(anc_x);
      vm_y_q   <= 10'(cur_q.py) - 10'(anc_y);
      tap_ok_q <= !rotated_q && drift_ok;
    end
    if (state_q == ST_SQUARE) begin
      sqa_x_q <= mag9(va_x_q) * mag9(va_x_q);
      sqa_y_q <= mag9(va_y_q) * mag9(va_y_q);
      sqm_x_q <= mag10(vm_x_q) * mag10(vm_x_q);
      sqm_y_q <= mag10(vm_y_q) * mag10(vm_y_q);
    end
    if ((state_q == ST_ANGLE) && done_new && done_anc) begin
      ang_new_q <= angle_new;
      ang_anc_q <= angle_anc;
    end
  end

  // sequencer and gesture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rot_q       <= twgd_pkg::ROT_NONE;
      btn_q       <= twgd_pkg::BTN_NONE;
      in_ring_q   <= 1'b0;
      rotated_q   <= 1'b0;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      press_x_q   <= '0;
      press_y_q   <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
    end else begin
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i && item_ready_o) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          case (cur_q.kind)
            twgd_pkg::KIND_HOVER: begin
              out_valid_q <= 1'b1;
              rot_q       <= twgd_pkg::ROT_NONE;
              btn_q       <= twgd_pkg::BTN_NONE;
              state_q     <= ST_IDLE;
            end
            twgd_pkg::KIND_PRESS: begin
              press_x_q  <= cur_q.px;
              press_y_q  <= cur_q.py;
              anchor_x_q <= cur_q.px;
              anchor_y_q <= cur_q.py;
              rotated_q  <= 1'b0;
              state_q    <= ST_SQUARE;
            end
            default: begin
              state_q <= ST_SQUARE;
            end
          endcase
        end
        ST_SQUARE: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (cur_q.kind == twgd_pkg::KIND_RELEASE) begin
            out_valid_q <= 1'b1;
            rot_q       <= twgd_pkg::ROT_NONE;
            btn_q       <= tap_ok_q ? btn_class : twgd_pkg::BTN_NONE;
            in_ring_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            last_x_q <= cur_q.px;
            last_y_q <= cur_q.py;
            if (cordic_start) begin
              state_q <= ST_ANGLE;
            end else begin
              if (outside) begin
                in_ring_q <= 1'b0;
              end else if (!in_ring_q) begin
                // entering the ring re-anchors without a step
                in_ring_q  <= 1'b1;
                anchor_x_q <= cur_q.px;
                anchor_y_q <= cur_q.py;
              end
              out_valid_q <= 1'b1;
              rot_q       <= twgd_pkg::ROT_NONE;
              btn_q       <= twgd_pkg::BTN_NONE;
              state_q     <= ST_IDLE;
            end
          end
        end
        ST_ANGLE: begin
          if (done_new && done_anc) begin
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (rot_step != twgd_pkg::ROT_NONE) begin
            anchor_x_q <= cur_q.px;
            anchor_y_q <= cur_q.py;
            rotated_q  <= 1'b1;
          end
          out_valid_q <= 1'b1;
          rot_q       <= rot_step;
          btn_q       <= twgd_pkg::BTN_NONE;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/touch_wheel_gesture_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_wheel_gesture_decoder: touch samples to click-wheel events
// one result beat per sample beat: rotation steps while dragging in the ring,
// a button code on release of a short tap
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                      payload
//  -------   ---   ---------                      -------
//  s_axis    in    s_axis_tvalid / s_axis_tready  tdata: touch_x, touch_y; tuser: pen_down
//  m_axis    out   m_axis_tvalid / m_axis_tready  tdata: rotation, button
//  cfg       in    cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
//  a sample goes from queue to result register through the prep, square and
//  decide states (pen up while up ends in prep); when the move test passes,
//  two cordic lanes run 24 micro-rotations in parallel, followed by the angle
//  hand-off and step states; the two-entry queue keeps taking sample beats,
//  until full, while the back end works or a result beat waits on m_axis_tready
//  reset clears the queue, the pen and ring state and loads the register
//  defaults; cfg writes are always taken
//
module touch_wheel_gesture_decoder #(
  parameter int unsigned ANGLE_BITS = twgd_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [7:0] touch_x, [15:8] touch_y
  input  logic                              s_axis_tuser,   // [0] pen_down
  // event stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [1:0] rotation, [4:2] button
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [twgd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);

  // configuration registers
  logic [7:0]       center_x_q;
  logic [7:0]       center_y_q;
  twgd_pkg::cfg_t   cfg_q;

  // front to queue
  logic             push;
  logic             q_full;
  twgd_pkg::item_t  front_item;

  // queue to back
  logic             q_valid;
  logic             q_ready;
  twgd_pkg::item_t  q_item;

  // result fields
  logic [1:0]       rotation;
  logic [2:0]       button;

  assign cfg_ready_o = 1'b1;

  // unknown indexes fall through and are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q                 <= twgd_pkg::CENTER_X_RESET;
      center_y_q                 <= twgd_pkg::CENTER_Y_RESET;
      cfg_q.inner_radius         <= twgd_pkg::INNER_RADIUS_RESET;
      cfg_q.outer_radius         <= twgd_pkg::OUTER_RADIUS_RESET;
      cfg_q.center_button_radius <= twgd_pkg::CENTER_RADIUS_RESET;
      cfg_q.tap_drift_limit      <= twgd_pkg::DRIFT_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        twgd_pkg::REG_CENTER_X:      center_x_q                 <= cfg_data_i;
        twgd_pkg::REG_CENTER_Y:      center_y_q                 <= cfg_data_i;
        twgd_pkg::REG_INNER_RADIUS:  cfg_q.inner_radius         <= cfg_data_i[6:0];
        twgd_pkg::REG_OUTER_RADIUS:  cfg_q.outer_radius         <= cfg_data_i[6:0];
        twgd_pkg::REG_CENTER_RADIUS: cfg_q.center_button_radius <= cfg_data_i[6:0];
        twgd_pkg::REG_DRIFT_LIMIT:   cfg_q.tap_drift_limit      <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // intake: pen tracking and center-relative coordinates
  twgd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .pen_down_i (s_axis_tuser),
    .touch_x_i  (s_axis_tdata[7:0]),
    .touch_y_i  (s_axis_tdata[15:8]),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .full_i     (q_full),
    .push_o     (push),
    .item_o     (front_item)
  );

  // decoupling fifo
  twgd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .item_o  (q_item)
  );

  // evaluation and result register
  twgd_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .cfg_i        (cfg_q),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .rotation_o   (rotation),
    .button_o     (button)
  );

  assign m_axis_tdata = {3'b000, button, rotation};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the touch wheel gesture decoder
// feeds touch sample beats (presses, ring drags, taps and random noise) under
// several wheel settings, predicts every event beat with a cycle-free copy of
// the decoder and compares rotation and button of each beat in order
// ----------------------------------------------------------------------------
module testbench;
  import twgd_pkg::*;

  localparam int unsigned ABITS = ANGLE_BITS_DEFAULT;

  // an index that maps to no register, writes to it must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd6;

  // fixed rotations used to walk a point around the ring, scaled by 256:
  // 5, 15, 20, 30, 45, 90, 160 and 175 degrees
  localparam int TURN_COS [8] = '{255, 247, 241, 222, 181, 0, -241, -255};
  localparam int TURN_SIN [8] = '{22, 66, 88, 128, 181, 256, 88, 22};

  typedef struct {
    logic       pen;
    logic [7:0] x;
    logic [7:0] y;
  } touch_t;

  typedef struct {
    logic [1:0] rot;
    logic [2:0] btn;
  } wheel_event_t;

  // dut ports, all known from time zero
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata  = '0;   // [7:0] touch_x, [15:8] touch_y
  logic                   s_axis_tuser  = 1'b0; // [0] pen_down
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;         // [1:0] rotation, [4:2] button
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [7:0]             cfg_data_i    = '0;

  // wheel settings as the decoder should hold them
  int cfg_cx       = int'(CENTER_X_RESET);
  int cfg_cy       = int'(CENTER_Y_RESET);
  int ring_inner   = int'(INNER_RADIUS_RESET);
  int ring_outer   = int'(OUTER_RADIUS_RESET);
  int button_reach = int'(CENTER_RADIUS_RESET);
  int drift_limit  = int'(DRIFT_LIMIT_RESET);

  // gesture state of the predicted decoder
  bit pen_held, ring_active, wheel_turned;
  int anchor_px, anchor_py, press_px, press_py, last_px, last_py;

  touch_t       pending_touches [$];
  wheel_event_t due_events [$];
  int           samples_queued;
  int           samples_taken;
  int           mismatch_count;
  int           idle_pct = 25;   // chance in percent that a side idles in a cycle
  touch_t       cur_touch;

  touch_wheel_gesture_decoder #(
    .ANGLE_BITS(ABITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // heading of (x, y) in turn units: 24 vectoring micro-rotations on the
  // 16-bit scaled vector, left half plane folded over by half a turn first
  function automatic logic [ABITS-1:0] cordic_heading(int x, int y);
    longint      vx, vy, nx;
    logic [31:0] acc;
    if (x == 0 && y == 0) return '0;
    vx  = longint'(x) * 65536;
    vy  = longint'(y) * 65536;
    acc = '0;
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      // arithmetic shift of a signed value is a floor shift
      if (vy > 0) begin
        nx  = vx + (vy >>> i);
        vy  = vy - (vx >>> i);
        acc = acc + ATAN_TURN[i];
      end else begin
        nx  = vx - (vy >>> i);
        vy  = vy + (vx >>> i);
        acc = acc - ATAN_TURN[i];
      end
      vx = nx;
    end
    acc = acc + (32'd1 << (31 - ABITS));   // round half up
    return acc[31 -: ABITS];
  endfunction

  function automatic bit off_ring(int d);
    return d > ring_outer * ring_outer || d < ring_inner * ring_inner;
  endfunction

  function automatic logic [2:0] tap_button(int px, int py);
    int d;
    d = px * px + py * py;
    if (d <= button_reach * button_reach) return BTN_CENTER;
    if (off_ring(d)) return BTN_NONE;
    if (magnitude(py) > magnitude(px)) return (py < 0) ? BTN_MENU : BTN_PLAY;
    if (px > 0) return BTN_FORWARD;
    if (px < 0) return BTN_REWIND;
    return BTN_NONE;
  endfunction

  // advance the gesture state by one sample and queue the event it yields
  task automatic predict_event(input touch_t t);
    wheel_event_t    ev;
    int              px, py, d;
    logic [ABITS-1:0] delta;
    longint          u18, full;
    ev.rot = ROT_NONE;
    ev.btn = BTN_NONE;
    full   = longint'(1) << ABITS;
    if (t.pen) begin
      px = int'(t.x) - cfg_cx;
      py = int'(t.y) - cfg_cy;
      if (!pen_held) begin
        press_px     = px;
        press_py     = py;
        last_px      = px;
        last_py      = py;
        anchor_px    = px;
        anchor_py    = py;
        pen_held     = 1'b1;
        wheel_turned = 1'b0;
      end
      d = px * px + py * py;
      if (off_ring(d)) begin
        ring_active = 1'b0;
      end else if (!ring_active) begin
        // entering the ring only re-anchors
        ring_active = 1'b1;
        anchor_px   = px;
        anchor_py   = py;
      end else if ((px - anchor_px) * (px - anchor_px) + (py - anchor_py) * (py - anchor_py)
                   >= int'(MIN_MOVE_SQ)) begin
        delta = cordic_heading(px, py) - cordic_heading(anchor_px, anchor_py);
        u18   = 18 * longint'(delta);
        if (u18 > full && u18 < 10 * full) ev.rot = ROT_RIGHT;
        else if (u18 >= 10 * full && u18 < 17 * full) ev.rot = ROT_LEFT;
        if (ev.rot != ROT_NONE) begin
          anchor_px    = px;
          anchor_py    = py;
          wheel_turned = 1'b1;
        end
      end
      last_px = px;
      last_py = py;
    end else if (pen_held) begin
      if (!wheel_turned && magnitude(press_px - last_px) < drift_limit
          && magnitude(press_py - last_py) < drift_limit)
        ev.btn = tap_button((press_px + last_px) / 2, (press_py + last_py) / 2);
      ring_active = 1'b0;
      pen_held    = 1'b0;
    end
    due_events.push_back(ev);
  endtask

  // ---------------------------------------------------------------- stimulus

  // queue one sample, coordinates clamped to the screen
  task automatic put_touch(input bit pen, input int ax, input int ay);
    touch_t t;
    t.pen = pen;
    t.x   = (ax < 0) ? 8'd0 : (ax > 255) ? 8'd255 : ax[7:0];
    t.y   = (ay < 0) ? 8'd0 : (ay > 191) ? 8'd191 : ay[7:0];
    pending_touches.push_back(t);
    samples_queued++;
  endtask

  task automatic put_release();
    put_touch(1'b0, int'($urandom_range(255)), int'($urandom_range(191)));
  endtask

  task automatic turn_point(inout int px, inout int py, input int idx, input int dir);
    int nx;
    nx = (px * TURN_COS[idx] - dir * py * TURN_SIN[idx]) >>> 8;
    py = (dir * px * TURN_SIN[idx] + py * TURN_COS[idx]) >>> 8;
    px = nx;
  endtask

  // mostly angles that make a step, now and then a dead-zone or a big jump
  function automatic int pick_turn();
    return ($urandom_range(99) < 70) ? int'($urandom_range(4, 1)) : int'($urandom_range(7));
  endfunction

  // press somewhere on a circle inside the ring, walk around it, release
  task automatic drag_gesture();
    int lo, hi, px, py, dir, k;
    lo  = (ring_inner < ring_outer) ? ring_inner : ring_outer;
    hi  = (ring_inner < ring_outer) ? ring_outer : ring_inner;
    px  = int'($urandom_range(hi, lo));
    py  = 0;
    dir = $urandom_range(1) ? 1 : -1;
    for (k = $urandom_range(7); k > 0; k--) turn_point(px, py, pick_turn(), 1);
    put_touch(1'b1, cfg_cx + px, cfg_cy + py);
    for (k = $urandom_range(12, 2); k > 0; k--) begin
      if ($urandom_range(9) == 0) dir = -dir;
      turn_point(px, py, pick_turn(), dir);
      if ($urandom_range(7) == 0) px = px + int'($urandom_range(6)) - 3;
      put_touch(1'b1, cfg_cx + px, cfg_cy + py);
    end
    put_release();
  endtask

  // press anywhere near the wheel, wobble a little, release
  task automatic tap_gesture();
    int span, reach, px, py, k;
    span  = ring_outer + 12;
    reach = drift_limit + 2;
    px    = int'($urandom_range(2 * span)) - span;
    py    = int'($urandom_range(2 * span)) - span;
    put_touch(1'b1, cfg_cx + px, cfg_cy + py);
    for (k = $urandom_range(3); k > 0; k--)
      put_touch(1'b1, cfg_cx + px + int'($urandom_range(2 * reach)) - reach,
                cfg_cy + py + int'($urandom_range(2 * reach)) - reach);
    put_release();
  endtask

  task automatic random_traffic(input int count);
    int goal, roll;
    goal = samples_queued + count;
    while (samples_queued < goal) begin
      roll = $urandom_range(99);
      if (roll < 45) drag_gesture();
      else if (roll < 75) tap_gesture();
      else repeat ($urandom_range(4, 1))
        put_touch(1'($urandom_range(1)), int'($urandom_range(255)),
                  int'($urandom_range(191)));
    end
  endtask

  // ---------------------------------------------------------------- registers

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CENTER_X:      cfg_cx       = int'(val);
      REG_CENTER_Y:      cfg_cy       = int'(val);
      REG_INNER_RADIUS:  ring_inner   = int'(val[6:0]);
      REG_OUTER_RADIUS:  ring_outer   = int'(val[6:0]);
      REG_CENTER_RADIUS: button_reach = int'(val[6:0]);
      REG_DRIFT_LIMIT:   drift_limit  = int'(val[6:0]);
      default: ;
    endcase
  endtask

  task automatic set_wheel(input logic [7:0] cx, input logic [7:0] cy,
                           input logic [7:0] inner, input logic [7:0] outer,
                           input logic [7:0] reach, input logic [7:0] drift);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_INNER_RADIUS, inner);
    write_reg(REG_OUTER_RADIUS, outer);
    write_reg(REG_CENTER_RADIUS, reach);
    write_reg(REG_DRIFT_LIMIT, drift);
  endtask

  // random settings that keep the wheel mostly on screen; bit 7 of the
  // radius writes is junk that must be dropped
  task automatic random_wheel();
    set_wheel(8'($urandom_range(192, 64)), 8'($urandom_range(144, 48)),
              {1'($urandom_range(1)), 7'($urandom_range(50))},
              {1'($urandom_range(1)), 7'($urandom_range(127, 30))},
              {1'($urandom_range(1)), 7'($urandom_range(60))},
              {1'($urandom_range(1)), 7'($urandom_range(64))});
  endtask

  // wait until every queued sample went in and every event beat came out
  task automatic settle();
    do @(posedge clk_i); while (samples_taken != samples_queued || due_events.size() != 0);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin : drive_samples
    bit took;
    if (rst_ni) begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        predict_event(cur_touch);
        samples_taken++;
      end
      // valid holds until its beat is taken
      if (took || !s_axis_tvalid) begin
        if (pending_touches.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_touch     = pending_touches.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_touch.y, cur_touch.x};
          s_axis_tuser  <= cur_touch.pen;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic log_mismatch(input string what, input logic [1:0] want_rot,
                              input logic [2:0] want_btn);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected rotation %0d button %0d, got rotation %0d button %0d",
               $time, what, want_rot, want_btn, m_axis_tdata[1:0], m_axis_tdata[4:2]);
  endtask

  always @(posedge clk_i) begin : check_events
    wheel_event_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_events.size() == 0) begin
          log_mismatch("event beat with nothing due", ROT_NONE, BTN_NONE);
        end else begin
          want = due_events.pop_front();
          if (m_axis_tdata[1:0] != want.rot || m_axis_tdata[4:2] != want.btn)
            log_mismatch("event beat differs", want.rot, want.btn);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed samples under the reset settings (center 128,96)
    put_touch(1'b0, 255, 191);                        // pen up while up
    put_touch(1'b1, cfg_cx, cfg_cy);                  // zero vector press
    put_release();                                    // tap on the center button
    put_touch(1'b1, 0, 0);                            // far corner, outside the wheel
    put_release();
    put_touch(1'b1, cfg_cx, cfg_cy - 60);             // menu
    put_release();
    put_touch(1'b1, cfg_cx, cfg_cy + 60);             // play
    put_release();
    put_touch(1'b1, cfg_cx + 60, cfg_cy);             // forward
    put_release();
    put_touch(1'b1, cfg_cx - 60, cfg_cy);             // rewind
    put_release();
    put_touch(1'b1, cfg_cx + 60, cfg_cy);             // press in the ring
    put_touch(1'b1, cfg_cx + 52, cfg_cy + 30);        // 30 degree step
    put_touch(1'b1, cfg_cx + 54, cfg_cy + 33);        // short move, no step
    put_touch(1'b1, cfg_cx + 60, cfg_cy);             // step back the other way
    put_touch(1'b1, cfg_cx + 120, cfg_cy);            // leave the ring
    put_touch(1'b1, cfg_cx + 60, cfg_cy);             // re-enter, anchor only
    put_release();                                    // rotated, so no button
    put_touch(1'b1, cfg_cx + 60, cfg_cy);             // drift too large for a tap
    put_touch(1'b1, cfg_cx + 105, cfg_cy);
    put_release();
    put_touch(1'b1, cfg_cx - 51, cfg_cy - 1);         // odd negative midpoint
    put_touch(1'b1, cfg_cx - 50, cfg_cy - 2);
    put_release();
    settle();

    random_wheel();
    write_reg(REG_UNMAPPED, 8'($urandom_range(255)));
    random_traffic(245);
    settle();

    // wheel in the top left corner, widest ring, zero center button radius
    set_wheel(8'd0, 8'd0, 8'd0, 8'd127, 8'd0, 8'd127);
    random_traffic(245);
    settle();

    // opposite corner, inner radius beyond the outer one: empty ring
    set_wheel(8'd255, 8'd191, 8'd127, 8'd0, 8'd127, 8'd127);
    random_traffic(245);
    settle();

    // zero drift limit: no release can be a tap
    set_wheel(CENTER_X_RESET, CENTER_Y_RESET, 8'd24, 8'd76, 8'd40, 8'd0);
    random_traffic(245);
    settle();

    // reset settings again, with both sides streaming without gaps
    set_wheel(CENTER_X_RESET, CENTER_Y_RESET, 8'd24, 8'd76, 8'd40, 8'd40);
    idle_pct = 0;
    random_traffic(245);
    settle();
    idle_pct = 25;

    repeat (3) begin
      random_wheel();
      random_traffic(245);
      settle();
    end

    // leave room for stray beats
    repeat (64) @(posedge clk_i);
    if (due_events.size() != 0) begin
      $display("%0d event beats never arrived", due_events.size());
      mismatch_count += due_events.size();
    end
    if (mismatch_count == 0)
      $display("touch_wheel_gesture_decoder regression: pass");
    else
      $display("touch_wheel_gesture_decoder regression: fail");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("touch_wheel_gesture_decoder regression: fail");
    $finish;
  end

endmodule
